@@ rtl/pat_pkg.sv @@
// Package for the packet airtime calculator: widths, constants and shared types.
`timescale 1ns / 1ps
package pat_pkg;
   localparam int SF_W     = 4;
   localparam int BW_W     = 19;
   localparam int CR_W     = 3;
   localparam int PL_W     = 8;
   localparam int AIR_W    = 36;
   localparam int PSYM_W   = 10;
   localparam int UNITS_W  = 19;
   localparam int PROD_W   = 37;
   localparam int DVD_W    = 49;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 48;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [BW_W-1:0]  BW_MIN = 19'd7800;
   localparam logic [BW_W-1:0]  BW_MAX = 19'd500000;
   localparam logic [17:0]      US_SCALE = 18'd250000;

   localparam logic [CSR_IDX_W-1:0] REG_PREAMBLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRC      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMPLICIT = 2'd2;

   typedef struct packed {
      logic [PSYM_W-1:0] psym;
      logic              de;
      logic              bad;
   } side_type;
endpackage

@@ rtl/pat_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
`timescale 1ns / 1ps
module pat_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [pat_pkg::DVD_W-1:0]  in_dividend,
   input  logic [pat_pkg::BW_W-1:0]   in_divisor,
   input  pat_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [pat_pkg::AIR_W-1:0]  out_quo,
   output pat_pkg::side_type          out_side
);
   import pat_pkg::*;
   localparam int N = AIR_W;

   logic              vld_ff [N];
   logic [BW_W-1:0]   rem_ff [N];
   logic [N-1:0]      low_ff [N];
   logic [N-1:0]      quo_ff [N];
   logic [BW_W-1:0]   div_ff [N];
   side_type          side_ff [N];

   logic [BW_W-1:0]   rem_src [N];
   logic [N-1:0]      low_src [N];
   logic [N-1:0]      quo_src [N];
   logic [BW_W-1:0]   rem_in  [N];
   logic [N-1:0]      low_in  [N];
   logic [N-1:0]      quo_in  [N];
   logic [BW_W:0]     trial   [N];
   logic              ge      [N];

   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            // quotient fits in N bits, so the top bits are already below the divisor
            rem_src[k] = {{(BW_W-(DVD_W-N)){1'b0}}, in_dividend[DVD_W-1:N]};
            low_src[k] = in_dividend[N-1:0];
            quo_src[k] = '0;
         end else begin
            rem_src[k] = rem_ff[k-1];
            low_src[k] = low_ff[k-1];
            quo_src[k] = quo_ff[k-1];
         end
         trial[k]  = {rem_src[k], low_src[k][N-1]};
         ge[k]     = trial[k] >= {1'b0, (k == 0) ? in_divisor : div_ff[k-1]};
         rem_in[k] = ge[k] ? BW_W'(trial[k] - {1'b0, (k == 0) ? in_divisor : div_ff[k-1]})
                           : trial[k][BW_W-1:0];
         low_in[k] = {low_src[k][N-2:0], 1'b0};
         quo_in[k] = {quo_src[k][N-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            if (k == 0) begin
               div_ff[k]  <= in_divisor;
               side_ff[k] <= in_side;
            end else begin
               div_ff[k]  <= div_ff[k-1];
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < N; k++) vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = quo_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule

@@ rtl/packet_airtime_calc.sv @@
// Top level of the packet airtime calculator.
//  channel | dir | fields
//  req_    | in  | spread_factor, bandwidth_hz, coding_rate, payload_bytes
//  rsp_    | out | airtime_us, payload_symbols, low_rate_opt; tuser bad_setting
//  csr_    | in  | preamble_len, crc_enabled, implicit_header_mode
// One item per cycle while the output is not stalled; five front stages, then 36 divider
// stages, one quotient bit each, over the bandwidth.
// Reset is synchronous; it empties the pipeline and restores register defaults.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module packet_airtime_calc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // sf[3:0], bandwidth_hz[22:4], coding_rate[25:23], payload_bytes[33:26], zero pad
   input  logic [pat_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // airtime_us[35:0], payload_symbols[45:36], low_rate_opt[46], zero pad
   output logic [pat_pkg::RSP_W-1:0]     rsp_tdata,
   // bad_setting[0]
   output logic                          rsp_tuser,
   input  logic                          csr_we,
   input  logic [pat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pat_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import pat_pkg::*;

   logic [15:0] pre_ff;
   logic        crc_ff, ih_ff;
   logic        en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= 16'd8;
         crc_ff <= 1'b1;
         ih_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PREAMBLE: pre_ff <= csr_wdata;
            REG_CRC:      crc_ff <= csr_wdata[0];
            REG_IMPLICIT: ih_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [SF_W-1:0] sf;
   logic [BW_W-1:0] bw;
   logic [CR_W-1:0] cr;
   logic [PL_W-1:0] pl;
   assign sf = req_tdata[3:0];
   assign bw = req_tdata[22:4];
   assign cr = req_tdata[25:23];
   assign pl = req_tdata[33:26];

   // stage 1: range check, low-rate flag, ceiling numerator
   logic            bad_c, de_c;
   logic [12:0]     num_c;
   logic [5:0]      den_c;
   logic [11:0]     a_c;
   always_comb begin
      bad_c = (sf < 4'd7) || (sf > 4'd12) || (bw < BW_MIN) || (bw > BW_MAX) ||
              (cr < 3'd1) || (cr > 3'd4);
      de_c  = (20'd125 << sf) > {bw, 1'b0};
      den_c = {sf - {2'b0, de_c, 1'b0}, 2'b00};
      num_c = {2'b0, pl, 3'b0} + 13'd28 + (crc_ff ? 13'd16 : 13'd0)
              - (ih_ff ? 13'd20 : 13'd0) - {7'b0, sf, 2'b0};
      // non-positive numerator gives zero symbols after clamping
      a_c   = (!num_c[12] && num_c != 13'd0) ? 12'(num_c + {7'b0, den_c} - 13'd1) : 12'd0;
   end

   logic              s1_v_ff, s1_bad_ff, s1_de_ff;
   logic [SF_W-1:0]   s1_sf_ff;
   logic [BW_W-1:0]   s1_bw_ff;
   logic [CR_W-1:0]   s1_cr_ff;
   logic [5:0]        s1_den_ff;
   logic [11:0]       s1_a_ff;

   // stage 2: quotient of the ceiling division
   logic [13:0]       r_c;
   logic [7:0]        q_c;
   always_comb begin
      r_c = {2'b0, s1_a_ff};
      q_c = '0;
      for (int i = 7; i >= 0; i--) begin
         if (r_c >= (14'(s1_den_ff) << i)) begin
            r_c    = r_c - (14'(s1_den_ff) << i);
            q_c[i] = 1'b1;
         end
      end
   end

   logic              s2_v_ff, s2_bad_ff, s2_de_ff;
   logic [SF_W-1:0]   s2_sf_ff;
   logic [BW_W-1:0]   s2_bw_ff;
   logic [CR_W-1:0]   s2_cr_ff;
   logic [7:0]        s2_q_ff;

   // stage 3: payload symbols and quarter-symbol units
   logic [PSYM_W-1:0]  psym_c;
   logic [UNITS_W-1:0] units_c;
   always_comb begin
      psym_c  = {2'b0, s2_q_ff} * PSYM_W'({1'b0, s2_cr_ff} + 4'd4);
      if (s2_bad_ff) psym_c = '0;
      units_c = {1'b0, pre_ff, 2'b0} + 19'd49 + {7'b0, psym_c, 2'b0};
   end

   logic               s3_v_ff;
   logic [SF_W-1:0]    s3_sf_ff;
   logic [BW_W-1:0]    s3_bw_ff;
   logic [UNITS_W-1:0] s3_units_ff;
   side_type           s3_side_ff;

   logic               s4_v_ff;
   logic [SF_W-1:0]    s4_sf_ff;
   logic [BW_W-1:0]    s4_bw_ff;
   logic [PROD_W-1:0]  s4_prod_ff;
   side_type           s4_side_ff;

   logic               s5_v_ff;
   logic [BW_W-1:0]    s5_bw_ff;
   logic [DVD_W-1:0]   s5_dvd_ff;
   side_type           s5_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_bad_ff <= bad_c;
         s1_de_ff  <= de_c;
         s1_sf_ff  <= sf;
         s1_bw_ff  <= bw;
         s1_cr_ff  <= cr;
         s1_den_ff <= den_c;
         s1_a_ff   <= a_c;

         s2_bad_ff <= s1_bad_ff;
         s2_de_ff  <= s1_de_ff;
         s2_sf_ff  <= s1_sf_ff;
         s2_bw_ff  <= s1_bw_ff;
         s2_cr_ff  <= s1_cr_ff;
         s2_q_ff   <= q_c;

         s3_sf_ff    <= s2_sf_ff;
         s3_bw_ff    <= s2_bw_ff;
         s3_units_ff <= units_c;
         s3_side_ff  <= '{psym: psym_c, de: s2_de_ff & ~s2_bad_ff, bad: s2_bad_ff};

         s4_sf_ff   <= s3_sf_ff;
         s4_bw_ff   <= s3_bw_ff;
         s4_prod_ff <= PROD_W'(s3_units_ff) * PROD_W'(US_SCALE);
         s4_side_ff <= s3_side_ff;

         s5_bw_ff   <= s4_bw_ff;
         s5_dvd_ff  <= DVD_W'({12'b0, s4_prod_ff} << s4_sf_ff);
         s5_side_ff <= s4_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   logic [AIR_W-1:0] quo;
   side_type         oside;

   pat_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s5_v_ff),
      .in_dividend (s5_dvd_ff),
      .in_divisor  (s5_bw_ff),
      .in_side     (s5_side_ff),
      .out_valid   (rsp_tvalid),
      .out_quo     (quo),
      .out_side    (oside)
   );

   // advance the whole pipeline unless a finished item is held at the output
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign rsp_tdata = {1'b0, oside.de, oside.psym, (oside.bad ? {AIR_W{1'b0}} : quo)};
   assign rsp_tuser = oside.bad;
endmodule
